FILE: src/bis_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bilinear image scaler package
// Shared sizes, register indexes, opcodes, state codes and the command word
// passed from the front end to the back end.
// -----------------------------------------------------------------------------
package bis_pkg;

   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int FRAC_BITS      = 16;

   // field widths fixed by the interface
   localparam int CRD_W      = 10;
   localparam int CFG_SIZE_W = 9;
   localparam int STEP_W     = 24;
   localparam int CCNT_W     = 3;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 4;
   localparam int PIX_W      = CH_W * NUM_CH;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int COL_W  = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_W  = $clog2(MAX_SRC_HEIGHT);
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int POS_W  = CRD_W + STEP_W;
   localparam int IP_W   = POS_W - FRAC_BITS;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_WIDTH  = 3'd0,
      REG_SRC_HEIGHT = 3'd1,
      REG_X_STEP     = 3'd2,
      REG_Y_STEP     = 3'd3,
      REG_CH_COUNT   = 3'd4
   } reg_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_FETCH
   } back_state_type;

   typedef struct packed {
      op_type                 op;
      logic [COL_W-1:0]       near_x;
      logic [COL_W-1:0]       far_x;
      logic [ROW_W-1:0]       near_y;
      logic [ROW_W-1:0]       far_y;
      logic [FRAC_BITS-1:0]   fx;
      logic [FRAC_BITS-1:0]   fy;
      logic                   four_ch;
      logic [PIX_W-1:0]       wdata;
   } cmd_type;

endpackage

FILE: src/bis_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bilinear image scaler front end
// Holds the configuration registers, takes request words, maps read
// coordinates to source neighbours and fractions, and issues commands.
// -----------------------------------------------------------------------------
module bis_front import bis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_op,
   input  logic [CRD_W-1:0]      req_col,
   input  logic [CRD_W-1:0]      req_row,
   input  logic [CH_W-1:0]       req_red_in,
   input  logic [CH_W-1:0]       req_green_in,
   input  logic [CH_W-1:0]       req_blue_in,
   input  logic [CH_W-1:0]       req_alpha_in,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  q_push,
   output cmd_type               q_cmd,
   input  logic                  q_full
);

   logic [CFG_SIZE_W-1:0] src_width_ff, src_height_ff;
   logic [STEP_W-1:0]     x_step_ff, y_step_ff;
   logic [CCNT_W-1:0]     ch_count_ff;

   logic                  a_valid_ff, a_valid_in;
   op_type                a_op_ff;
   logic [CRD_W-1:0]      a_col_ff, a_row_ff;
   logic [PIX_W-1:0]      a_pix_ff;
   logic [POS_W-1:0]      a_pos_x_ff, a_pos_y_ff;
   logic [POS_W-1:0]      pos_x_in, pos_y_in;

   logic                  accept, a_go, in_range;
   logic [COL_W-1:0]      last_col, near_x, far_x;
   logic [ROW_W-1:0]      last_row, near_y, far_y;
   logic [IP_W-1:0]       ip_x, ip_y;

   assign csr_ready = 1'b1;
   assign full      = a_valid_ff & q_full;
   assign accept    = push & ~full;
   assign a_go      = a_valid_ff & ~q_full;

   assign pos_x_in = POS_W'(req_col) * POS_W'(x_step_ff);
   assign pos_y_in = POS_W'(req_row) * POS_W'(y_step_ff);

   always_comb begin
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_go) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         src_width_ff  <= CFG_SIZE_W'(256);
         src_height_ff <= CFG_SIZE_W'(256);
         x_step_ff     <= STEP_W'(1 << FRAC_BITS);
         y_step_ff     <= STEP_W'(1 << FRAC_BITS);
         ch_count_ff   <= CCNT_W'(4);
      end else begin
         a_valid_ff <= a_valid_in;
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_SRC_WIDTH:  src_width_ff  <= csr_data[CFG_SIZE_W-1:0];
               REG_SRC_HEIGHT: src_height_ff <= csr_data[CFG_SIZE_W-1:0];
               REG_X_STEP:     x_step_ff     <= csr_data[STEP_W-1:0];
               REG_Y_STEP:     y_step_ff     <= csr_data[STEP_W-1:0];
               REG_CH_COUNT:   ch_count_ff   <= csr_data[CCNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_op_ff    <= op_type'(req_op);
         a_col_ff   <= req_col;
         a_row_ff   <= req_row;
         a_pix_ff   <= {req_alpha_in, req_blue_in, req_green_in, req_red_in};
         a_pos_x_ff <= pos_x_in;
         a_pos_y_ff <= pos_y_in;
      end
   end

   // last valid column and row, with zero sizes acting as one
   always_comb begin
      if (src_width_ff == '0) begin
         last_col = '0;
      end else if (int'(src_width_ff) > MAX_SRC_WIDTH) begin
         last_col = COL_W'(MAX_SRC_WIDTH - 1);
      end else begin
         last_col = COL_W'(src_width_ff - CFG_SIZE_W'(1));
      end
      if (src_height_ff == '0) begin
         last_row = '0;
      end else if (int'(src_height_ff) > MAX_SRC_HEIGHT) begin
         last_row = ROW_W'(MAX_SRC_HEIGHT - 1);
      end else begin
         last_row = ROW_W'(src_height_ff - CFG_SIZE_W'(1));
      end
   end

   // at or past the last column or row both neighbours collapse onto it
   always_comb begin
      ip_x = a_pos_x_ff[POS_W-1:FRAC_BITS];
      ip_y = a_pos_y_ff[POS_W-1:FRAC_BITS];
      if (ip_x >= IP_W'(last_col)) begin
         near_x = last_col;
         far_x  = last_col;
      end else begin
         near_x = ip_x[COL_W-1:0];
         far_x  = ip_x[COL_W-1:0] + COL_W'(1);
      end
      if (ip_y >= IP_W'(last_row)) begin
         near_y = last_row;
         far_y  = last_row;
      end else begin
         near_y = ip_y[ROW_W-1:0];
         far_y  = ip_y[ROW_W-1:0] + ROW_W'(1);
      end
   end

   assign in_range = (int'(a_col_ff) < MAX_SRC_WIDTH) && (int'(a_row_ff) < MAX_SRC_HEIGHT);

   // drop writes outside the store
   assign q_push = a_go & ((a_op_ff == OP_READ) | in_range);

   always_comb begin
      q_cmd.op      = a_op_ff;
      q_cmd.fx      = a_pos_x_ff[FRAC_BITS-1:0];
      q_cmd.fy      = a_pos_y_ff[FRAC_BITS-1:0];
      q_cmd.four_ch = (ch_count_ff >= CCNT_W'(4));
      q_cmd.wdata   = a_pix_ff;
      if (a_op_ff == OP_READ) begin
         q_cmd.near_x = near_x;
         q_cmd.far_x  = far_x;
         q_cmd.near_y = near_y;
         q_cmd.far_y  = far_y;
      end else begin
         q_cmd.near_x = a_col_ff[COL_W-1:0];
         q_cmd.far_x  = a_col_ff[COL_W-1:0];
         q_cmd.near_y = a_row_ff[ROW_W-1:0];
         q_cmd.far_y  = a_row_ff[ROW_W-1:0];
      end
   end

endmodule

FILE: src/bis_cmd_fifo.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bilinear image scaler command queue
// Two-entry queue that decouples the front end from the back end.
// -----------------------------------------------------------------------------
module bis_cmd_fifo import bis_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_push,
   input  cmd_type in_cmd,
   output logic    in_full,
   input  logic    out_pop,
   output logic    out_valid,
   output cmd_type out_cmd
);

   localparam int CMD_DEPTH = 2;
   localparam int PTR_W     = $clog2(CMD_DEPTH);
   localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

   cmd_type            entry_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign in_full   = (count_ff == CNT_W'(CMD_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = in_push & ~in_full;
   assign do_pop    = out_pop & out_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

FILE: src/bis_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bilinear image scaler back end
// Owns the pixel store, fetches the four neighbours of a read in turn,
// blends them horizontally then vertically, and queues the results.
// -----------------------------------------------------------------------------
module bis_back import bis_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cmd_type          cmd,
   output logic             cmd_pop,
   output logic             empty,
   input  logic             pop,
   output logic [CH_W-1:0]  rsp_red_out,
   output logic [CH_W-1:0]  rsp_green_out,
   output logic [CH_W-1:0]  rsp_blue_out,
   output logic [CH_W-1:0]  rsp_alpha_out
);

   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int RSP_DEPTH   = 4;
   localparam int RPTR_W      = $clog2(RSP_DEPTH);
   localparam int RCNT_W      = $clog2(RSP_DEPTH + 1);
   localparam int HSUM_W      = CH_W + FRAC_BITS;
   localparam int HPROD_W     = CH_W + FRAC_BITS + 2;
   localparam int VPROD_W     = HSUM_W + FRAC_BITS + 2;

   localparam logic [1:0] PH_TL = 2'd0;
   localparam logic [1:0] PH_TR = 2'd1;
   localparam logic [1:0] PH_BL = 2'd2;
   localparam logic [1:0] PH_BR = 2'd3;

   back_state_type        state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   cmd_type               cur_ff;

   logic [PIX_W-1:0]      pixel_mem [STORE_DEPTH];
   logic [PIX_W-1:0]      rd_data_ff;
   logic [ADDR_W-1:0]     mem_addr;
   logic                  mem_we;

   logic                  tag_valid_ff;
   logic [1:0]            tag_phase_ff;
   logic [PIX_W-1:0]      left_ff;
   logic [HSUM_W-1:0]     top_ff    [NUM_CH];
   logic [HSUM_W-1:0]     bottom_ff [NUM_CH];
   logic [HSUM_W-1:0]     horiz     [NUM_CH];
   logic [FRAC_BITS-1:0]  bl_fx_ff, bl_fy_ff;
   logic                  bl_four_ff;
   logic                  blend_go_ff;
   logic [PIX_W-1:0]      blend_pix;

   logic signed [HPROD_W-1:0] h_diff [NUM_CH];
   logic signed [HPROD_W-1:0] h_sum  [NUM_CH];
   logic signed [VPROD_W-1:0] v_diff [NUM_CH];
   logic signed [VPROD_W-1:0] v_sum  [NUM_CH];

   logic [RCNT_W-1:0]     inflight_ff;
   logic [PIX_W-1:0]      rsp_mem [RSP_DEPTH];
   logic [RPTR_W-1:0]     rsp_wr_ptr_ff, rsp_rd_ptr_ff;
   logic [RCNT_W-1:0]     rsp_count_ff;
   logic [PIX_W-1:0]      rsp_head;
   logic [RCNT_W:0]       reserved;
   logic                  read_room, can_start_read, start_read, do_write, rsp_take;

   // a read may start only if its result already has a slot
   assign reserved       = (RCNT_W+1)'(rsp_count_ff) + (RCNT_W+1)'(inflight_ff);
   assign read_room      = (int'(reserved) < RSP_DEPTH);
   assign can_start_read = cmd_valid & (cmd.op == OP_READ) & read_room;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (can_start_read) begin
               state_in = BK_FETCH;
            end
         end
         BK_FETCH: begin
            if (phase_ff == PH_BR && !can_start_read) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      start_read = 1'b0;
      do_write   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            start_read = can_start_read;
            do_write   = cmd_valid & (cmd.op == OP_WRITE);
         end
         BK_FETCH: begin
            start_read = can_start_read & (phase_ff == PH_BR);
         end
         default: ;
      endcase
   end

   assign cmd_pop  = start_read | do_write;
   assign mem_we   = do_write;
   assign phase_in = (state_ff == BK_FETCH) ? phase_ff + 2'd1 : PH_TL;

   always_comb begin
      if (state_ff == BK_FETCH) begin
         case (phase_ff)
            PH_TL:   mem_addr = {cur_ff.near_y, cur_ff.near_x};
            PH_TR:   mem_addr = {cur_ff.near_y, cur_ff.far_x};
            PH_BL:   mem_addr = {cur_ff.far_y, cur_ff.near_x};
            default: mem_addr = {cur_ff.far_y, cur_ff.far_x};
         endcase
      end else begin
         mem_addr = {cmd.near_y, cmd.near_x};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_addr] <= cmd.wdata;
      end
      rd_data_ff <= pixel_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         phase_ff     <= PH_TL;
         tag_valid_ff <= 1'b0;
         blend_go_ff  <= 1'b0;
         inflight_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         tag_valid_ff <= (state_ff == BK_FETCH);
         blend_go_ff  <= tag_valid_ff & (tag_phase_ff == PH_BR);
         if (start_read && !blend_go_ff) begin
            inflight_ff <= inflight_ff + RCNT_W'(1);
         end else if (blend_go_ff && !start_read) begin
            inflight_ff <= inflight_ff - RCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_phase_ff <= phase_ff;
      if (start_read) begin
         cur_ff <= cmd;
      end
   end

   // horizontal blend: a + (b - a) * fx, scaled by 2^FRAC_BITS
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         h_diff[c] = $signed(HPROD_W'(rd_data_ff[c*CH_W +: CH_W]))
                   - $signed(HPROD_W'(left_ff[c*CH_W +: CH_W]));
         h_sum[c]  = $signed(HPROD_W'({left_ff[c*CH_W +: CH_W], {FRAC_BITS{1'b0}}}))
                   + h_diff[c] * $signed(HPROD_W'(bl_fx_ff));
         horiz[c]  = h_sum[c][HSUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (tag_valid_ff) begin
         case (tag_phase_ff)
            PH_TL: begin
               left_ff    <= rd_data_ff;
               bl_fx_ff   <= cur_ff.fx;
               bl_fy_ff   <= cur_ff.fy;
               bl_four_ff <= cur_ff.four_ch;
            end
            PH_TR: begin
               top_ff <= horiz;
            end
            PH_BL: begin
               left_ff <= rd_data_ff;
            end
            default: begin
               bottom_ff <= horiz;
            end
         endcase
      end
   end

   // vertical blend, then keep the integer part; the fourth channel is zeroed unless four_ch
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         v_diff[c] = $signed(VPROD_W'(bottom_ff[c])) - $signed(VPROD_W'(top_ff[c]));
         v_sum[c]  = $signed(VPROD_W'({top_ff[c], {FRAC_BITS{1'b0}}}))
                   + v_diff[c] * $signed(VPROD_W'(bl_fy_ff));
         blend_pix[c*CH_W +: CH_W] = v_sum[c][2*FRAC_BITS +: CH_W];
      end
      if (!bl_four_ff) begin
         blend_pix[(NUM_CH-1)*CH_W +: CH_W] = '0;
      end
   end

   assign empty    = (rsp_count_ff == '0);
   assign rsp_take = pop & ~empty;
   assign rsp_head = rsp_mem[rsp_rd_ptr_ff];

   assign rsp_red_out   = rsp_head[0*CH_W +: CH_W];
   assign rsp_green_out = rsp_head[1*CH_W +: CH_W];
   assign rsp_blue_out  = rsp_head[2*CH_W +: CH_W];
   assign rsp_alpha_out = rsp_head[3*CH_W +: CH_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ptr_ff <= '0;
         rsp_rd_ptr_ff <= '0;
         rsp_count_ff  <= '0;
      end else begin
         if (blend_go_ff) begin
            rsp_wr_ptr_ff <= rsp_wr_ptr_ff + RPTR_W'(1);
         end
         if (rsp_take) begin
            rsp_rd_ptr_ff <= rsp_rd_ptr_ff + RPTR_W'(1);
         end
         if (blend_go_ff && !rsp_take) begin
            rsp_count_ff <= rsp_count_ff + RCNT_W'(1);
         end else if (rsp_take && !blend_go_ff) begin
            rsp_count_ff <= rsp_count_ff - RCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (blend_go_ff) begin
         rsp_mem[rsp_wr_ptr_ff] <= blend_pix;
      end
   end

   a_no_overbook: assert property (@(posedge clock) disable iff (reset)
      int'(reserved) <= RSP_DEPTH)
      else $error("result slots overbooked");

   a_blend_has_slot: assert property (@(posedge clock) disable iff (reset)
      blend_go_ff |-> (int'(rsp_count_ff) < RSP_DEPTH))
      else $error("result written into a full queue");

   a_fetch_to_blend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FETCH && phase_ff == PH_BR) |-> ##2 blend_go_ff)
      else $error("last neighbour fetch not followed by blend");

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      blend_go_ff |-> (inflight_ff != '0))
      else $error("blend with no read in flight");

endmodule

FILE: src/bilinear_image_scaler.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Bilinear image scaler
// Frame store with bilinear resampling reads.
// Reads are fetched one at a time, each reading its four neighbours in turn
// from the single-port pixel store; writes are taken only between reads.
// Reset: clears control and restores register defaults; the pixel store is
// not cleared and needs no clearing pass.
// -----------------------------------------------------------------------------
module bilinear_image_scaler import bis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_op,
   input  logic [CRD_W-1:0]      req_col,
   input  logic [CRD_W-1:0]      req_row,
   input  logic [CH_W-1:0]       req_red_in,
   input  logic [CH_W-1:0]       req_green_in,
   input  logic [CH_W-1:0]       req_blue_in,
   input  logic [CH_W-1:0]       req_alpha_in,
   output logic                  empty,
   input  logic                  pop,
   output logic [CH_W-1:0]       rsp_red_out,
   output logic [CH_W-1:0]       rsp_green_out,
   output logic [CH_W-1:0]       rsp_blue_out,
   output logic [CH_W-1:0]       rsp_alpha_out,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic    q_push, q_full, q_valid, q_pop;
   cmd_type q_in_cmd, q_out_cmd;

   bis_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_op        (req_op),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_alpha_in  (req_alpha_in),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .q_push        (q_push),
      .q_cmd         (q_in_cmd),
      .q_full        (q_full)
   );

   bis_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_push   (q_push),
      .in_cmd    (q_in_cmd),
      .in_full   (q_full),
      .out_pop   (q_pop),
      .out_valid (q_valid),
      .out_cmd   (q_out_cmd)
   );

   bis_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_valid),
      .cmd           (q_out_cmd),
      .cmd_pop       (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_alpha_out (rsp_alpha_out)
   );

endmodule
